// ===== rtl/core/go_to_goal_p_controller_assert.svh =====
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_assert.svh
// Assertion macros for the go-to-goal controller. Define ASSERT_OFF to drop
// every check.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_P_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define GTG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("go_to_goal_p_controller check failed");
// Next-cycle implication
`define GTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("go_to_goal_p_controller check failed");
`else
`define GTG_ASSERT_IMP(label, clk, rst, ante, cons)
`define GTG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// gtg_pkg
// Types, constants and the arctangent table of the go-to-goal controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

   // Algorithm constants
   localparam int CORDIC_ITERATIONS      = 16;
   localparam int POSITION_FRACTION_BITS = 10;
   localparam int ATAN_ENTRIES           = 24;

   // Field widths
   localparam int POS_W     = 16;
   localparam int HEAD_W    = 16;
   localparam int GAIN_W    = 12;
   localparam int RADIUS_W  = 15;
   localparam int SPEED_W   = 18;
   localparam int RATE_W    = 20;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Datapath widths
   localparam int DIFF_W       = POS_W + 1;          // goal minus pose
   localparam int XY_W         = 28;                 // CORDIC x and y
   localparam int Z_W          = 21;                 // CORDIC angle, Q.16
   localparam int BEAR_W       = Z_W - 4;            // bearing, Q.12
   localparam int DIST_W       = 17;
   localparam int INV_GAIN_W   = 16;
   localparam int DIST_PROD_W  = (XY_W - 1) + INV_GAIN_W;
   localparam int ERR_W        = HEAD_W + 2;
   localparam int SPEED_PROD_W = GAIN_W + DIST_W;
   localparam int SPEED_SUM_W  = SPEED_PROD_W + 1;
   localparam int SPEED_SH     = POSITION_FRACTION_BITS - 2;
   localparam int SPEED_FULL_W = SPEED_SUM_W - SPEED_SH;
   localparam int RATE_PROD_W  = ERR_W + GAIN_W + 1;
   localparam int RATE_SUM_W   = RATE_PROD_W + 1;
   localparam int RATE_FULL_W  = RATE_SUM_W - 8;
   localparam int CNT_W        = $clog2(CORDIC_ITERATIONS);

   localparam int PI_Q16       = 205887;
   localparam int INV_GAIN_Q16 = 39797;
   localparam int SPEED_MAX    = 262143;
   localparam int RATE_MAX     = 524287;
   localparam int RATE_MIN     = -524288;

   // Register reset values
   localparam logic signed [POS_W-1:0]  GOAL_X_RESET       = 16'sd1024;
   localparam logic signed [POS_W-1:0]  GOAL_Y_RESET       = 16'sd1024;
   localparam logic [GAIN_W-1:0]        LINEAR_GAIN_RESET  = 12'd384;
   localparam logic [GAIN_W-1:0]        ANGULAR_GAIN_RESET = 12'd1024;
   localparam logic [RADIUS_W-1:0]      STOP_RADIUS_RESET  = 15'd10;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GOAL_X       = 3'd0,
      CSR_GOAL_Y       = 3'd1,
      CSR_LINEAR_GAIN  = 3'd2,
      CSR_ANGULAR_GAIN = 3'd3,
      CSR_STOP_RADIUS  = 3'd4
   } csr_index_type;

   // Payloads
   typedef struct packed {
      logic signed [POS_W-1:0]  pose_x;
      logic signed [POS_W-1:0]  pose_y;
      logic signed [HEAD_W-1:0] pose_heading;
   } req_payload_type;

   typedef struct packed {
      logic [SPEED_W-1:0]        linear_speed;
      logic signed [RATE_W-1:0]  angular_rate;
      logic                      is_stop;
      logic                      last;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic iterate;
      logic scale;
      logic round_dist;
      logic gain;
      logic emit_cmd;
      logic emit_stop;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic iter_done;
      logic near;
      logic out_free;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ITER,
      ST_SCALE,
      ST_ROUND,
      ST_GAIN,
      ST_EMIT_CMD,
      ST_EMIT_STOP
   } ctrl_state_type;

   // Arctangent of 2^-i in Q.16, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = Z_W'(51472);
         5'd1:    val = Z_W'(30386);
         5'd2:    val = Z_W'(16055);
         5'd3:    val = Z_W'(8150);
         5'd4:    val = Z_W'(4091);
         5'd5:    val = Z_W'(2047);
         5'd6:    val = Z_W'(1024);
         5'd7:    val = Z_W'(512);
         5'd8:    val = Z_W'(256);
         5'd9:    val = Z_W'(128);
         5'd10:   val = Z_W'(64);
         5'd11:   val = Z_W'(32);
         5'd12:   val = Z_W'(16);
         5'd13:   val = Z_W'(8);
         5'd14:   val = Z_W'(4);
         5'd15:   val = Z_W'(2);
         5'd16:   val = Z_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/gtg_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtg_ctrl
// Sequencer: accepts a pose, steps the datapath through the CORDIC and the
// gain stages, emits the command beat and, on arrival, the stop beat.
// ----------------------------------------------------------------------------
module gtg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gtg_pkg::dp_status_type dp_status,
   output gtg_pkg::dp_cmd_type    dp_cmd
);

   gtg_pkg::ctrl_state_type state_ff, state_in;
   logic                    arrived_ff, arrived_in;

   // State and arrival flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gtg_pkg::ST_IDLE;
         arrived_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         arrived_ff <= arrived_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      arrived_in = arrived_ff;
      dp_cmd     = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         gtg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            // once arrived, accept and drop every pose
            if (req_valid && !arrived_ff) begin
               dp_cmd.start = 1'b1;
               state_in     = gtg_pkg::ST_ITER;
            end
         end
         gtg_pkg::ST_ITER: begin
            dp_cmd.iterate = 1'b1;
            if (dp_status.iter_done) begin
               state_in = gtg_pkg::ST_SCALE;
            end
         end
         gtg_pkg::ST_SCALE: begin
            dp_cmd.scale = 1'b1;
            state_in     = gtg_pkg::ST_ROUND;
         end
         gtg_pkg::ST_ROUND: begin
            dp_cmd.round_dist = 1'b1;
            state_in          = gtg_pkg::ST_GAIN;
         end
         gtg_pkg::ST_GAIN: begin
            dp_cmd.gain = 1'b1;
            state_in    = gtg_pkg::ST_EMIT_CMD;
         end
         gtg_pkg::ST_EMIT_CMD: begin
            if (dp_status.out_free) begin
               dp_cmd.emit_cmd = 1'b1;
               if (dp_status.near) begin
                  arrived_in = 1'b1;
                  state_in   = gtg_pkg::ST_EMIT_STOP;
               end else begin
                  state_in = gtg_pkg::ST_IDLE;
               end
            end
         end
         gtg_pkg::ST_EMIT_STOP: begin
            if (dp_status.out_free) begin
               dp_cmd.emit_stop = 1'b1;
               state_in         = gtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gtg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/gtg_datapath.sv =====
// ----------------------------------------------------------------------------
// gtg_datapath
// Goal registers, iterative CORDIC vectoring unit, distance scaling, gain
// multipliers, saturation and the result output register.
// ----------------------------------------------------------------------------
module gtg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  gtg_pkg::req_payload_type            req_payload,
   input  logic                                csr_write,
   input  logic [gtg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]      csr_data,
   input  gtg_pkg::dp_cmd_type                 dp_cmd,
   output gtg_pkg::dp_status_type              dp_status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gtg_pkg::rsp_payload_type            rsp_payload
);

   localparam int XY_W    = gtg_pkg::XY_W;
   localparam int Z_W     = gtg_pkg::Z_W;
   localparam int DIFF_W  = gtg_pkg::DIFF_W;
   localparam int DIST_W  = gtg_pkg::DIST_W;
   localparam int ERR_W   = gtg_pkg::ERR_W;
   localparam int CNT_W   = gtg_pkg::CNT_W;

   // Configuration registers
   logic signed [gtg_pkg::POS_W-1:0]   goal_x_ff, goal_y_ff;
   logic [gtg_pkg::GAIN_W-1:0]         linear_gain_ff, angular_gain_ff;
   logic [gtg_pkg::RADIUS_W-1:0]       stop_radius_ff;

   // Working registers
   logic signed [XY_W-1:0]                      x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]                       z_ff, z_in;
   logic [CNT_W-1:0]                            cnt_ff, cnt_in;
   logic                                        zero_ff, zero_in;
   logic signed [gtg_pkg::HEAD_W-1:0]           heading_ff, heading_in;
   logic [gtg_pkg::DIST_PROD_W-1:0]             dist_prod_ff, dist_prod_in;
   logic signed [gtg_pkg::BEAR_W-1:0]           bearing_ff, bearing_in;
   logic [DIST_W-1:0]                           dist_ff, dist_in;
   logic signed [ERR_W-1:0]                     err_ff, err_in;
   logic [gtg_pkg::SPEED_PROD_W-1:0]            speed_prod_ff, speed_prod_in;
   logic signed [gtg_pkg::RATE_PROD_W-1:0]      rate_prod_ff, rate_prod_in;
   gtg_pkg::rsp_payload_type                    rsp_ff, rsp_in;
   logic                                        rsp_valid_ff, rsp_valid_in;

   // Combinational helpers
   logic signed [DIFF_W-1:0]                    dx, dy;
   logic signed [XY_W-1:0]                      x0, y0, xs, ys;
   logic signed [Z_W-1:0]                       step_angle, z_round;
   logic [gtg_pkg::DIST_PROD_W-1:0]             dist_round;
   logic [gtg_pkg::SPEED_SUM_W-1:0]             speed_sum;
   logic [gtg_pkg::SPEED_FULL_W-1:0]            speed_full;
   logic [gtg_pkg::SPEED_W-1:0]                 speed_sat;
   logic signed [gtg_pkg::RATE_SUM_W-1:0]       rate_sum;
   logic signed [gtg_pkg::RATE_FULL_W-1:0]      rate_full;
   logic signed [gtg_pkg::RATE_W-1:0]           rate_sat;
   logic                                        near;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff       <= gtg_pkg::GOAL_X_RESET;
         goal_y_ff       <= gtg_pkg::GOAL_Y_RESET;
         linear_gain_ff  <= gtg_pkg::LINEAR_GAIN_RESET;
         angular_gain_ff <= gtg_pkg::ANGULAR_GAIN_RESET;
         stop_radius_ff  <= gtg_pkg::STOP_RADIUS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gtg_pkg::CSR_GOAL_X:       goal_x_ff       <= csr_data;
            gtg_pkg::CSR_GOAL_Y:       goal_y_ff       <= csr_data;
            gtg_pkg::CSR_LINEAR_GAIN:  linear_gain_ff  <= csr_data[gtg_pkg::GAIN_W-1:0];
            gtg_pkg::CSR_ANGULAR_GAIN: angular_gain_ff <= csr_data[gtg_pkg::GAIN_W-1:0];
            gtg_pkg::CSR_STOP_RADIUS:  stop_radius_ff  <= csr_data[gtg_pkg::RADIUS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Goal minus pose, scaled by 256
   always_comb begin
      dx = DIFF_W'(goal_x_ff) - DIFF_W'(req_payload.pose_x);
      dy = DIFF_W'(goal_y_ff) - DIFF_W'(req_payload.pose_y);
      x0 = {{(XY_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'd0};
      y0 = {{(XY_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'd0};
   end

   // CORDIC micro-rotation for the current iteration
   always_comb begin
      xs         = x_ff >>> cnt_ff;
      ys         = y_ff >>> cnt_ff;
      step_angle = gtg_pkg::atan_q16(5'(cnt_ff));
   end

   // Rounding and saturation
   always_comb begin
      z_round    = z_ff + Z_W'(8);
      dist_round = dist_prod_ff + (gtg_pkg::DIST_PROD_W'(1) << 23);
      speed_sum  = gtg_pkg::SPEED_SUM_W'(speed_prod_ff)
                 + (gtg_pkg::SPEED_SUM_W'(1) << (gtg_pkg::SPEED_SH - 1));
      speed_full = speed_sum[gtg_pkg::SPEED_SUM_W-1:gtg_pkg::SPEED_SH];
      if (speed_full > gtg_pkg::SPEED_FULL_W'(gtg_pkg::SPEED_MAX)) begin
         speed_sat = gtg_pkg::SPEED_W'(gtg_pkg::SPEED_MAX);
      end else begin
         speed_sat = speed_full[gtg_pkg::SPEED_W-1:0];
      end
      rate_sum  = gtg_pkg::RATE_SUM_W'(rate_prod_ff) + gtg_pkg::RATE_SUM_W'(128);
      rate_full = rate_sum[gtg_pkg::RATE_SUM_W-1:8];
      if (rate_full > gtg_pkg::RATE_FULL_W'(gtg_pkg::RATE_MAX)) begin
         rate_sat = gtg_pkg::RATE_W'(gtg_pkg::RATE_MAX);
      end else if (rate_full < gtg_pkg::RATE_FULL_W'(gtg_pkg::RATE_MIN)) begin
         rate_sat = gtg_pkg::RATE_W'(gtg_pkg::RATE_MIN);
      end else begin
         rate_sat = rate_full[gtg_pkg::RATE_W-1:0];
      end
      near = dist_ff <= DIST_W'(stop_radius_ff);
   end

   // Next values of the working registers
   always_comb begin
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      cnt_in        = cnt_ff;
      zero_in       = zero_ff;
      heading_in    = heading_ff;
      dist_prod_in  = dist_prod_ff;
      bearing_in    = bearing_ff;
      dist_in       = dist_ff;
      err_in        = err_ff;
      speed_prod_in = speed_prod_ff;
      rate_prod_in  = rate_prod_ff;
      rsp_in        = rsp_ff;

      if (dp_cmd.start) begin
         zero_in    = (dx == '0) && (dy == '0);
         heading_in = req_payload.pose_heading;
         cnt_in     = '0;
         if (dx[DIFF_W-1]) begin
            x_in = -x0;
            y_in = -y0;
            z_in = dy[DIFF_W-1] ? -Z_W'(gtg_pkg::PI_Q16) : Z_W'(gtg_pkg::PI_Q16);
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end

      // Rotate toward the x axis
      if (dp_cmd.iterate) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (!y_ff[XY_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_angle;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_angle;
         end
      end

      // Remove CORDIC gain; round the bearing to Q.12
      if (dp_cmd.scale) begin
         dist_prod_in = gtg_pkg::DIST_PROD_W'(x_ff[XY_W-2:0])
                      * gtg_pkg::DIST_PROD_W'(gtg_pkg::INV_GAIN_Q16);
         bearing_in   = zero_ff ? '0 : z_round[Z_W-1:4];
      end

      if (dp_cmd.round_dist) begin
         dist_in = zero_ff ? '0 : dist_round[24 +: DIST_W];
         err_in  = ERR_W'(bearing_ff) - ERR_W'(heading_ff);
      end

      if (dp_cmd.gain) begin
         speed_prod_in = gtg_pkg::SPEED_PROD_W'(linear_gain_ff)
                       * gtg_pkg::SPEED_PROD_W'(dist_ff);
         rate_prod_in  = gtg_pkg::RATE_PROD_W'(err_ff)
                       * gtg_pkg::RATE_PROD_W'($signed({1'b0, angular_gain_ff}));
      end

      if (dp_cmd.emit_cmd) begin
         rsp_in.linear_speed = speed_sat;
         rsp_in.angular_rate = rate_sat;
         rsp_in.is_stop      = 1'b0;
         rsp_in.last         = !near;
      end else if (dp_cmd.emit_stop) begin
         rsp_in.linear_speed = '0;
         rsp_in.angular_rate = '0;
         rsp_in.is_stop      = 1'b1;
         rsp_in.last         = 1'b1;
      end
   end

   // Output beat valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.emit_cmd || dp_cmd.emit_stop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      zero_ff       <= zero_in;
      heading_ff    <= heading_in;
      dist_prod_ff  <= dist_prod_in;
      bearing_ff    <= bearing_in;
      dist_ff       <= dist_in;
      err_ff        <= err_in;
      speed_prod_ff <= speed_prod_in;
      rate_prod_ff  <= rate_prod_in;
      rsp_ff        <= rsp_in;
   end

   assign dp_status.iter_done = cnt_ff == CNT_W'(gtg_pkg::CORDIC_ITERATIONS - 1);
   assign dp_status.near      = near;
   assign dp_status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload         = rsp_ff;

endmodule

// ===== rtl/core/go_to_goal_p_controller.sv =====
// Sequence: a pose is accepted in idle, then 16 CORDIC iterations run on one shared
//   rotator, followed by scale, round, gain and emit steps; on arrival the stop beat
//   follows as soon as the command beat is taken. A new pose is accepted only after
//   the emit steps of the previous one, and the emit waits while the output is stalled.
// Reset: synchronous; restores goal and gain registers and clears arrival.
// ----------------------------------------------------------------------------
// go_to_goal_p_controller
// Proportional go-to-goal controller: distance and bearing by CORDIC
// vectoring, speed and turn-rate commands with saturation, stop on arrival.
// ----------------------------------------------------------------------------
`include "go_to_goal_p_controller_assert.svh"

module go_to_goal_p_controller (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gtg_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gtg_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gtg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]    csr_data
);

   gtg_pkg::dp_cmd_type    dp_cmd;
   gtg_pkg::dp_status_type dp_status;

   // Registers take a write beat in any cycle
   assign csr_ready = 1'b1;

   gtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   gtg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Stop beat carries zero commands and closes the item
   `GTG_ASSERT_IMP(a_stop_beat_zero, clock, reset, rsp_valid && rsp_payload.is_stop, rsp_payload.last && rsp_payload.linear_speed == '0 && rsp_payload.angular_rate == '0)
   // At most one datapath step per cycle
   `GTG_ASSERT_IMP(a_cmd_onehot, clock, reset, 1'b1, $onehot0(dp_cmd))
   // Work starts only on an accepted pose
   `GTG_ASSERT_IMP(a_start_on_accept, clock, reset, dp_cmd.start, req_valid && !req_stall)
   // Stop command lands in the output register
   `GTG_ASSERT_NEXT(a_stop_loaded, clock, reset, dp_cmd.emit_stop, rsp_valid && rsp_payload.is_stop && rsp_payload.last)

endmodule
